// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int WordW  = 32;
	localparam int FifoDepth = 4;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PadByte = 8'h80;

	// classified beat handed from front to back
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} sha1_beat_t;

	function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
		if (rnd < 7'd20) return K0;
		else if (rnd < 7'd40) return K1;
		else if (rnd < 7'd60) return K2;
		else return K3;
	endfunction

	function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		if (rnd < 7'd20) return (x & y) ^ (~x & z);
		else if (rnd >= 7'd40 && rnd < 7'd60) return (x & y) ^ (x & z) ^ (y & z);
		else return x ^ y ^ z;
	endfunction

endpackage

// ===== rtl/core/sha1_front.sv =====
// ----------------------------------------------------------------------------
// sha1_front
// Accepts message beats, clamps byte counts and queues them for the core.
// ----------------------------------------------------------------------------
module sha1_front import sha1_pkg::*; #(
	parameter int Depth = FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        final_word,
	output logic        q_valid,
	input  logic        q_take,
	output sha1_beat_t  q_beat
);
	localparam int AW = $clog2(Depth);

	sha1_beat_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;
	sha1_beat_t    beat;

	assign stall   = (cnt_q == (AW+1)'(Depth));
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != '0);
	assign pop     = q_valid && q_take;
	assign q_beat  = mem_q[rd_q];

	always_comb begin
		beat.word = message_word;
		beat.last = final_word;
		if (!final_word || valid_bytes > 3'd4) beat.nbytes = 3'd4;
		else beat.nbytes = valid_bytes;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/sha1_core.sv =====
// ----------------------------------------------------------------------------
// sha1_core
// Block assembly, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1_core import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_take,
	input  sha1_beat_t  q_beat,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);
	localparam logic [2:0] ST_IN   = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [3:0]  slot_q;
	logic [63:0] len_q;
	logic [6:0]  rnd_q;
	logic        padding_q;   // block being compressed is part of padding
	logic        extra_q;     // 0x80 word still owed (four-byte final)
	logic        len_next_q;  // 0x80 landed in slot 14, length goes in next block
	logic        len_written_q;
	logic [2:0]  oidx_q;

	logic [31:0] pad_word, wsched, wcur, t;
	logic [31:0] keep;
	logic [3:0]  ri;
	logic        wr_en;
	logic [31:0] wr_data;

	assign ri = rnd_q[3:0];
	assign wsched = w_q[ri+4'd13] ^ w_q[ri+4'd8] ^ w_q[ri+4'd2] ^ w_q[ri];
	assign wcur = (rnd_q >= 7'd16) ? {wsched[30:0], wsched[31]} : w_q[ri];
	assign t = {a_q[26:0], a_q[31:27]} + sha1_f(rnd_q, b_q, c_q, d_q) + e_q
		+ sha1_k(rnd_q) + wcur;

	assign q_take = (state_q == ST_IN);

	always_comb begin
		case (q_beat.nbytes)
			3'd0: keep = 32'h0;
			3'd1: keep = 32'hff000000;
			3'd2: keep = 32'hffff0000;
			3'd3: keep = 32'hffffff00;
			default: keep = 32'hffffffff;
		endcase
		case (q_beat.nbytes)
			3'd0: pad_word = {PadByte, 24'h0};
			3'd1: pad_word = {8'h0, PadByte, 16'h0};
			3'd2: pad_word = {16'h0, PadByte, 8'h0};
			3'd3: pad_word = {24'h0, PadByte};
			default: pad_word = 32'h0;
		endcase
		pad_word = pad_word | (q_beat.word & keep);
	end

	// word to store this cycle (input or padding)
	always_comb begin
		wr_en = 1'b0;
		wr_data = 32'h0;
		if (state_q == ST_IN && q_valid) begin
			wr_en = 1'b1;
			wr_data = pad_word;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			if (extra_q) wr_data = {PadByte, 24'h0};
			else if (!len_next_q && slot_q == 4'd14) wr_data = len_q[63:32];
			else if (!len_next_q && slot_q == 4'd15) wr_data = len_q[31:0];
			else wr_data = 32'h0;
		end
	end

	assign out_valid    = (state_q == ST_OUT);
	assign digest_word  = h_q[oidx_q];
	assign digest_index = oidx_q;
	assign digest_last  = (oidx_q == 3'd4);

	always_ff @(posedge clk) begin
		if (wr_en) w_q[slot_q] <= wr_data;
		else if (state_q == ST_RND && rnd_q >= 7'd16) w_q[ri] <= wcur;
		if (state_q == ST_RND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IN;
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			slot_q    <= '0;
			len_q     <= '0;
			rnd_q     <= '0;
			padding_q <= 1'b0;
			extra_q   <= 1'b0;
			len_next_q <= 1'b0;
			len_written_q <= 1'b0;
			oidx_q    <= '0;
		end else begin
			case (state_q)
				ST_IN: begin
					if (q_valid) begin
						slot_q <= slot_q + 4'd1;
						len_q  <= len_q + {58'h0, q_beat.nbytes, 3'b000};
						if (q_beat.last) begin
							padding_q  <= 1'b1;
							extra_q    <= (q_beat.nbytes == 3'd4);
							len_next_q <= (q_beat.nbytes != 3'd4) && (slot_q == 4'd14);
						end
						if (slot_q == 4'd15) begin
							rnd_q <= '0;
							state_q <= ST_RND;
						end else if (q_beat.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					extra_q <= 1'b0;
					slot_q <= slot_q + 4'd1;
					if (slot_q == 4'd15) begin
						len_next_q <= 1'b0;
						if (!extra_q && !len_next_q) len_written_q <= 1'b1;
						rnd_q <= '0;
						state_q <= ST_RND;
					end else if (extra_q) begin
						len_next_q <= (slot_q == 4'd14);
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (!padding_q) state_q <= ST_IN;
					else if (len_written_q) begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end else state_q <= ST_PAD;
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) begin
							h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2;
							h_q[3] <= H3; h_q[4] <= H4;
							slot_q <= '0;
							len_q <= '0;
							padding_q <= 1'b0;
							len_written_q <= 1'b0;
							state_q <= ST_IN;
						end
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end
endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a stream of 32-bit message words, five digest beats per message.
// ----------------------------------------------------------------------------
// Each beat is queued by the front end; the core stores one word per cycle
// while beats are queued and runs one round per cycle. A 16-word block is
// stored, put through 80 rounds and added into the hash; no words are taken
// meanwhile. After the final beat the core writes padding words one per cycle,
// runs one or two more compressions, then sends five digest beats, index 0
// first. The input stays open while the queue has room.
module sha1_stream_hasher import sha1_pkg::*; #(
	parameter int Depth = FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);
	logic       q_valid, q_take;
	sha1_beat_t q_beat;

	sha1_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.message_word, .valid_bytes, .final_word,
		.q_valid, .q_take, .q_beat
	);

	sha1_core u_core (
		.clk, .arst_n, .q_valid, .q_take, .q_beat,
		.out_valid, .out_stall, .digest_word, .digest_index, .digest_last
	);
endmodule
